// ===== sv/order_preserving_alphabet_remap_assert.svh =====
// Assertion macros shared by the order-preserving alphabet remap RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ORDER_PRESERVING_ALPHABET_REMAP_ASSERT_SVH
`define ORDER_PRESERVING_ALPHABET_REMAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define OPAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define OPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define OPAR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/opar_pkg.sv =====
// Package for the order-preserving alphabet remap: widths, codes and the
// queue item type. Used by the front end, the back end and the top level.
package opar_pkg;

  localparam int SYM_W             = 8;
  localparam int DIST_W            = 9;
  localparam int ALPHABET_SIZE_DEF = 256;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_REMAP = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_REMAP  = 2'd1,
    ST_CANNOT    = 2'd2,
    ST_UNMAPPED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_SWEEP,
    BK_DONE
  } back_state_t;

  // One queued beat, classified by the front end.
  typedef struct packed {
    cmd_t             op;
    logic [SYM_W-1:0] sym;
    logic             in_range;
  } item_t;

endpackage

// ===== sv/opar_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module opar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/opar_front.sv =====
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on opar_pkg.
module opar_front #(
  parameter int ALPHABET_SIZE = opar_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_cmd,
  input  logic [opar_pkg::SYM_W-1:0] in_symbol,
  output logic                      q_vld,
  output opar_pkg::item_t           q_item,
  input  logic                      q_pop
);
  import opar_pkg::*;

  `include "order_preserving_alphabet_remap_assert.svh"

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  item_t       new_item;

  assign busy  = (cnt_r == 2'd2);
  assign push  = start && !busy;
  assign q_vld = (cnt_r != 2'd0);
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    new_item.op       = cmd_t'(in_cmd);
    new_item.sym      = in_symbol;
    new_item.in_range = ({1'b0, in_symbol} < 9'(ALPHABET_SIZE));
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ (q_pop && q_vld);
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop && q_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  `OPAR_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `OPAR_ASSERT_NOW(a_no_pop_empty, clk, rst_n, q_pop, q_vld)
  `OPAR_ASSERT_NOW(a_ptr_gap, clk, rst_n, cnt_r == 2'd1, wr_ptr_r != rd_ptr_r)

endmodule

// ===== sv/opar_back.sv =====
// Back end: executes queued beats against the presence bits, the map RAM
// and the valid bits, and sweeps the alphabet on a build. Depends on
// opar_pkg and opar_ram.
module opar_back #(
  parameter int ALPHABET_SIZE = opar_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [opar_pkg::SYM_W-1:0]  reserved_below,
  input  logic                        q_vld,
  input  opar_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_strobe,
  output logic [opar_pkg::SYM_W-1:0]  out_mapped_symbol,
  output logic [1:0]                  out_status,
  output logic [opar_pkg::DIST_W-1:0] out_distinct_symbols
);
  import opar_pkg::*;

  `include "order_preserving_alphabet_remap_assert.svh"

  localparam int AW = $clog2(ALPHABET_SIZE);

  back_state_t          state_r, state_nxt;
  logic [ALPHABET_SIZE-1:0] seen_r, seen_nxt;
  logic [ALPHABET_SIZE-1:0] valid_r, valid_nxt;
  logic                 ready_r, ready_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic                 low_r, low_nxt;
  logic [SYM_W:0]       jump_r, jump_nxt;
  logic                 res_vld_r, res_vld_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [DIST_W-1:0]    res_dist_r, res_dist_nxt;
  logic                 rm_pend_r, rm_pend_nxt;
  logic                 hit_r, hit_nxt;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [SYM_W-1:0]     ram_wdata;
  logic [SYM_W-1:0]     ram_rdata;
  logic [AW-1:0]        q_idx;
  logic                 sweep_last;
  logic                 cannot;

  assign q_idx      = q_item.sym[AW-1:0];
  assign sweep_last = (cnt_r == AW'(ALPHABET_SIZE - 1));
  assign cannot     = ((10'(dist_r) + 10'(reserved_below)) >= 10'(ALPHABET_SIZE));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (q_vld && q_item.op == CMD_BUILD) begin
          state_nxt = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        if (sweep_last) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    seen_nxt       = seen_r;
    valid_nxt      = valid_r;
    ready_nxt      = ready_r;
    cnt_nxt        = cnt_r;
    dist_nxt       = dist_r;
    low_nxt        = low_r;
    jump_nxt       = jump_r;
    res_vld_nxt    = 1'b0;
    res_status_nxt = res_status_r;
    res_dist_nxt   = res_dist_r;
    rm_pend_nxt    = 1'b0;
    hit_nxt        = hit_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = q_idx;
    ram_wdata      = SYM_W'(9'(cnt_r) + jump_r);
    case (state_r)
      BK_RUN: begin
        if (q_vld) begin
          q_pop = 1'b1;
          case (q_item.op)
            CMD_COUNT: begin
              if (q_item.in_range) begin
                seen_nxt[q_idx] = 1'b1;
              end
              res_vld_nxt    = 1'b1;
              res_status_nxt = ST_OK;
              res_dist_nxt   = '0;
            end
            CMD_REMAP: begin
              rm_pend_nxt = 1'b1;
              hit_nxt     = ready_r && q_item.in_range && valid_r[q_idx];
            end
            CMD_BUILD: begin
              // Entries present now get valid bits; the sweep fills their map words.
              valid_nxt = seen_r;
              ready_nxt = 1'b0;
              cnt_nxt   = '0;
              dist_nxt  = '0;
              low_nxt   = 1'b0;
              jump_nxt  = 9'(reserved_below) + 9'd1;
            end
            CMD_CLEAR: begin
              seen_nxt       = '0;
              valid_nxt      = '0;
              ready_nxt      = 1'b0;
              res_vld_nxt    = 1'b1;
              res_status_nxt = ST_OK;
              res_dist_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      BK_SWEEP: begin
        ram_addr = cnt_r;
        cnt_nxt  = cnt_r + AW'(1);
        if (seen_r[cnt_r]) begin
          ram_we   = 1'b1;
          dist_nxt = dist_r + DIST_W'(1);
          if (8'(cnt_r) <= reserved_below) begin
            low_nxt = 1'b1;
          end
        end else if (jump_r != '0) begin
          jump_nxt = jump_r - 9'd1;
        end
      end
      BK_DONE: begin
        res_vld_nxt  = 1'b1;
        res_dist_nxt = dist_r;
        ready_nxt    = !cannot;
        if (cannot) begin
          res_status_nxt = ST_CANNOT;
        end else if (low_r) begin
          res_status_nxt = ST_OK;
        end else begin
          // Nothing sits in the reserved range, so the sweep built the identity map.
          res_status_nxt = ST_NO_REMAP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_RUN;
      seen_r    <= '0;
      valid_r   <= '0;
      ready_r   <= 1'b0;
      res_vld_r <= 1'b0;
      rm_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seen_r    <= seen_nxt;
      valid_r   <= valid_nxt;
      ready_r   <= ready_nxt;
      res_vld_r <= res_vld_nxt;
      rm_pend_r <= rm_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    dist_r       <= dist_nxt;
    low_r        <= low_nxt;
    jump_r       <= jump_nxt;
    res_status_r <= res_status_nxt;
    res_dist_r   <= res_dist_nxt;
    hit_r        <= hit_nxt;
  end

  opar_ram #(
    .WIDTH (SYM_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // A remap result comes straight off the RAM read register.
  assign out_strobe           = res_vld_r || rm_pend_r;
  assign out_mapped_symbol    = (rm_pend_r && hit_r) ? ram_rdata : '0;
  assign out_status           = rm_pend_r ? (hit_r ? ST_OK : ST_UNMAPPED) : res_status_r;
  assign out_distinct_symbols = rm_pend_r ? '0 : res_dist_r;

  `OPAR_ASSERT_NOW(a_no_pop_sweep, clk, rst_n, state_r != BK_RUN, !q_pop)
  `OPAR_ASSERT_NOW(a_one_result, clk, rst_n, rm_pend_r, !res_vld_r)
  `OPAR_ASSERT_NOW(a_we_sweep, clk, rst_n, ram_we, state_r == BK_SWEEP)
  `OPAR_ASSERT_NEXT(a_done_result, clk, rst_n, state_r == BK_DONE,
                    res_vld_r && state_r == BK_RUN)

endmodule

// ===== sv/order_preserving_alphabet_remap.sv =====
// Top level of the order-preserving alphabet remap: configuration register,
// front-end queue and back-end executor. Depends on opar_pkg and submodules.
//
// Count, clear and remap beats never hold the back end, so a steady stream
// of them runs at one beat per cycle; a result is registered as its beat
// leaves the queue, a remap included, since its map word is loaded into
// the RAM read register at the same edge as the rest of the result. A
// build beat sweeps the alphabet through the map RAM write port one entry
// per cycle and holds the back end through the sweep and the done state;
// the two-entry queue then fills and busy rises. Every beat gives exactly
// one result, shown for one cycle with out_strobe; the receiver cannot
// stall it. The user must write reserved_below through cfg_we and
// cfg_wdata only while the block is idle; the block does not enforce it.
module order_preserving_alphabet_remap #(
  parameter int ALPHABET_SIZE = opar_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [opar_pkg::SYM_W-1:0]  in_symbol,
  output logic                        out_strobe,
  output logic [opar_pkg::SYM_W-1:0]  out_mapped_symbol,
  output logic [1:0]                  out_status,
  output logic [opar_pkg::DIST_W-1:0] out_distinct_symbols,
  input  logic                        cfg_we,
  input  logic [opar_pkg::SYM_W-1:0]  cfg_wdata
);
  import opar_pkg::*;

  logic [SYM_W-1:0] reserved_below_r, reserved_below_nxt;
  logic             q_vld;
  item_t            q_item;
  logic             q_pop;

  assign reserved_below_nxt = cfg_we ? cfg_wdata : reserved_below_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_below_r <= '0;
    end else begin
      reserved_below_r <= reserved_below_nxt;
    end
  end

  opar_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .in_symbol (in_symbol),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  opar_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .reserved_below       (reserved_below_r),
    .q_vld                (q_vld),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_strobe           (out_strobe),
    .out_mapped_symbol    (out_mapped_symbol),
    .out_status           (out_status),
    .out_distinct_symbols (out_distinct_symbols)
  );

endmodule
